@@ rtl/core/dzvc_pkg.sv @@
// Shared constants and types for the delta/zigzag/varint codec.
package dzvc_pkg;

    localparam int SAMPLE_WIDTH = 32;
    localparam int GROUP_BITS   = 7;
    localparam int MAX_GROUPS   = (SAMPLE_WIDTH + GROUP_BITS - 1) / GROUP_BITS;
    localparam int CNT_W        = $clog2(MAX_GROUPS + 1);

    localparam logic [7:0] PAYLOAD_MASK = 8'h7f;
    localparam logic [7:0] MORE_BIT     = 8'h80;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_TRUNC = 2'd1,
        ERR_LONG  = 2'd2
    } err_t;

    typedef struct packed {
        logic [SAMPLE_WIDTH-1:0] sample_in;
        logic [7:0]              code_byte;
        logic                    start_sequence;
        logic                    end_of_string;
    } item_t;

    // Work handed from the step logic to the output stage.
    typedef struct packed {
        logic                    enc;
        logic [SAMPLE_WIDTH-1:0] data;
        logic                    last;
        err_t                    err;
    } load_t;

endpackage

@@ rtl/core/dzvc_ifs.sv @@
// Handshake channel interfaces for the codec: input items, results, configuration.
interface dzvc_item_if;
    import dzvc_pkg::*;
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;
    logic [7:0]                     code_byte;
    logic                           start_sequence;
    logic                           end_of_string;

    modport source (output valid, sample_in, code_byte, start_sequence, end_of_string,
                    input ready);
    modport sink   (input valid, sample_in, code_byte, start_sequence, end_of_string,
                    output ready);
endinterface

interface dzvc_result_if;
    import dzvc_pkg::*;
    logic                           valid;
    logic                           ready;
    logic [7:0]                     byte_out;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           last_of_run;
    logic [1:0]                     error_code;

    modport source (output valid, byte_out, sample_out, last_of_run, error_code,
                    input ready);
    modport sink   (input valid, byte_out, sample_out, last_of_run, error_code,
                    output ready);
endinterface

interface dzvc_cfg_if;
    logic valid;
    logic ready;
    logic decode_mode;

    modport source (output valid, decode_mode, input ready);
    modport sink   (input valid, decode_mode, output ready);
endinterface

@@ rtl/core/dzvc_step.sv @@
// Per-word step logic: running value, decoder group state, encode/decode math.
module dzvc_step
    import dzvc_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  accept,
    input  logic  decode_mode,
    input  item_t item,
    output logic  load_valid,
    output load_t load
);

    logic [SAMPLE_WIDTH-1:0] rv_reg, rv_next;
    logic [SAMPLE_WIDTH-1:0] acc_reg, acc_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;

    logic [SAMPLE_WIDTH-1:0] rv_cur, acc_cur, acc_new;
    logic [CNT_W-1:0]        cnt_cur, cnt_new;
    logic [SAMPLE_WIDTH-1:0] diff, zz, unzz, rv_sum, group_bits;
    logic [6:0]              payload;

    assign rv_cur  = item.start_sequence ? '0 : rv_reg;
    assign acc_cur = item.start_sequence ? '0 : acc_reg;
    assign cnt_cur = item.start_sequence ? '0 : cnt_reg;

    // Encode: wrap-around delta, then zigzag.
    assign diff = item.sample_in - rv_cur;
    assign zz   = {diff[SAMPLE_WIDTH-2:0], 1'b0} ^ {SAMPLE_WIDTH{diff[SAMPLE_WIDTH-1]}};

    // Decode: place the 7-bit group at its position; bits above the word drop.
    assign payload = item.code_byte[6:0];
    always_comb
    begin
        group_bits = '0;
        for (int g = 0; g < MAX_GROUPS; g++)
        begin
            if (cnt_cur == CNT_W'(g))
            begin
                group_bits = SAMPLE_WIDTH'(({{SAMPLE_WIDTH{1'b0}}, payload})
                                           << (GROUP_BITS * g));
            end
        end
    end

    assign acc_new = acc_cur | group_bits;
    assign cnt_new = cnt_cur + CNT_W'(1);
    assign unzz    = {1'b0, acc_new[SAMPLE_WIDTH-1:1]} ^ {SAMPLE_WIDTH{acc_new[0]}};
    assign rv_sum  = rv_cur + unzz;

    always_comb
    begin
        rv_next    = rv_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        load_valid = 1'b0;
        load.enc   = 1'b0;
        load.data  = '0;
        load.last  = 1'b0;
        load.err   = ERR_NONE;
        if (accept)
        begin
            rv_next  = rv_cur;
            acc_next = acc_cur;
            cnt_next = cnt_cur;
            if (!decode_mode)
            begin
                rv_next    = item.sample_in;
                load_valid = 1'b1;
                load.enc   = 1'b1;
                load.data  = zz;
                load.last  = 1'b1;
            end
            else if (!item.code_byte[7])
            begin
                rv_next    = rv_sum;
                acc_next   = '0;
                cnt_next   = '0;
                load_valid = 1'b1;
                load.data  = rv_sum;
                load.last  = 1'b1;
            end
            else if (cnt_new == CNT_W'(MAX_GROUPS))
            begin
                acc_next   = '0;
                cnt_next   = '0;
                load_valid = 1'b1;
                load.err   = ERR_LONG;
            end
            else if (item.end_of_string)
            begin
                acc_next   = '0;
                cnt_next   = '0;
                load_valid = 1'b1;
                load.err   = ERR_TRUNC;
            end
            else
            begin
                acc_next = acc_new;
                cnt_next = cnt_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rv_reg  <= '0;
            acc_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rv_reg  <= rv_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(MAX_GROUPS))
        else $error("group count reached the group limit");

    a_cnt_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && decode_mode && !item.code_byte[7]) |=> (cnt_reg == '0 && acc_reg == '0))
        else $error("group state not cleared after a final byte");

endmodule

@@ rtl/core/dzvc_emit.sv @@
// Result register: holds one decoded word or walks the bytes of one encoded sample.
module dzvc_emit
    import dzvc_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    load_valid,
    input  load_t                   load,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [7:0]              byte_out,
    output logic [SAMPLE_WIDTH-1:0] sample_out,
    output logic                    last_of_run,
    output logic [1:0]              error_code,
    output logic                    free
);

    logic                    valid_reg, valid_next;
    logic                    enc_reg, enc_next;
    logic [SAMPLE_WIDTH-1:0] data_reg, data_next;
    logic                    last_reg, last_next;
    err_t                    err_reg, err_next;
    logic [CNT_W-1:0]        grp_reg, grp_next;

    logic more;
    logic take;

    assign more = enc_reg && (|data_reg[SAMPLE_WIDTH-1:GROUP_BITS])
                  && (grp_reg < CNT_W'(MAX_GROUPS - 1));
    assign take = valid_reg && out_ready;
    assign free = !valid_reg || (take && !more);

    assign out_valid   = valid_reg;
    assign byte_out    = enc_reg ? ({more, data_reg[6:0]} & (MORE_BIT | PAYLOAD_MASK)) : 8'h00;
    assign sample_out  = enc_reg ? '0 : data_reg;
    assign last_of_run = enc_reg ? !more : last_reg;
    assign error_code  = enc_reg ? 2'(ERR_NONE) : 2'(err_reg);

    always_comb
    begin
        valid_next = valid_reg;
        enc_next   = enc_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        err_next   = err_reg;
        grp_next   = grp_reg;
        if (take && more)
        begin
            // advance to the next 7-bit group
            data_next = data_reg >> GROUP_BITS;
            grp_next  = grp_reg + CNT_W'(1);
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        if (load_valid)
        begin
            valid_next = 1'b1;
            enc_next   = load.enc;
            data_next  = load.data;
            last_next  = load.last;
            err_next   = load.err;
            grp_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            grp_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            grp_reg   <= grp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        enc_reg  <= enc_next;
        data_reg <= data_next;
        last_reg <= last_next;
        err_reg  <= err_next;
    end

    a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> grp_reg < CNT_W'(MAX_GROUPS))
        else $error("byte index past the group limit");

    a_more_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (take && more) |=> (valid_reg && enc_reg))
        else $error("encoded sample dropped before its last byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (load_valid && valid_reg) |-> (take && !more))
        else $error("result register overwritten while a word is pending");

    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !enc_reg && err_reg != ERR_NONE) |-> (!last_reg && data_reg == '0))
        else $error("error word carries a sample");

endmodule

@@ rtl/core/delta_zigzag_varint_codec_top.sv @@
// Top level of the delta/zigzag/varint codec.
//
//  channel  dir   handshake       payload
//  item     in    valid/ready     sample_in, code_byte, start_sequence, end_of_string
//  result   out   valid/ready     byte_out, sample_out, last_of_run, error_code
//  cfg      in    valid/ready     decode_mode (always ready)
//
// Decode: one byte per cycle unless result stalls, with its result in the next cycle.
// Encode loads a sample and emits 1 to 5 bytes from the result register, one per
// cycle unless result stalls; the next sample goes in the cycle the last byte leaves.
// A stall on result holds the result register and blocks item until it frees up.
// Reset clears the running value, the group state and the decode_mode register.
module delta_zigzag_varint_codec_top
    import dzvc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dzvc_item_if.sink     item,
    dzvc_result_if.source result,
    dzvc_cfg_if.sink      cfg
);

    logic  decode_mode_reg;
    logic  accept;
    logic  free;
    logic  load_valid;
    load_t load;
    item_t item_word;
    logic [SAMPLE_WIDTH-1:0] sample_bits;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decode_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            decode_mode_reg <= cfg.decode_mode;
        end
    end

    assign item.ready = free;
    assign accept     = item.valid && free;

    assign item_word.sample_in      = item.sample_in;
    assign item_word.code_byte      = item.code_byte;
    assign item_word.start_sequence = item.start_sequence;
    assign item_word.end_of_string  = item.end_of_string;

    dzvc_step u_step (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .decode_mode (decode_mode_reg),
        .item        (item_word),
        .load_valid  (load_valid),
        .load        (load)
    );

    dzvc_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .load_valid  (load_valid),
        .load        (load),
        .out_ready   (result.ready),
        .out_valid   (result.valid),
        .byte_out    (result.byte_out),
        .sample_out  (sample_bits),
        .last_of_run (result.last_of_run),
        .error_code  (result.error_code),
        .free        (free)
    );

    assign result.sample_out = $signed(sample_bits);

endmodule
